>>> design/keyframe_linear_interpolator_defines.svh
// assertion macros for the keyframe interpolator
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define KLI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KLI_ASSERT(lbl, clk, rst, prop, msg)
`define KLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/kli_pkg.sv
package kli_pkg;

  localparam int KEY_DEPTH_DEF = 64;
  localparam int TIME_W        = 32;
  localparam int VAL_W         = 32;
  localparam int FRAC_W        = 16;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  localparam logic [1:0] ST_EVAL  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_OK    = 2'd3;

  // one stored key, time in the lowest bits
  typedef struct packed {
    logic signed [VAL_W-1:0] z;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] x;
    logic [TIME_W-1:0]       t;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

endpackage

>>> design/keyframe_linear_interpolator.sv
// clear and append: result registered through the response state into the output register, store written on accept
// evaluate: worst case set by the one-key-a-cycle scan of the key memory, the serial divider
//   for the segment fraction and a shared multiplier
// one item at a time; a new item is taken once the previous result is in the output register
// rst is synchronous: key count cleared to an empty curve, no item in flight, key memory not cleared
`include "keyframe_linear_interpolator_defines.svh"

module keyframe_linear_interpolator #(
  parameter int KEY_DEPTH = kli_pkg::KEY_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // time_req, value_x, value_y, value_z
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // out_x, out_y, out_z
  output logic [1:0]   m_tuser    // status
);

  localparam int AW = $clog2(KEY_DEPTH);
  localparam int CW = $clog2(KEY_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RDL  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]               state;
  logic [CW-1:0]            count;
  logic [1:0]               mul_cnt;
  logic [1:0]               col_cnt;
  logic [kli_pkg::TIME_W-1:0] t_q;
  kli_pkg::key_t            lo;
  kli_pkg::key_t            hi;
  logic [AW-1:0]            idx;
  logic signed [kli_pkg::VAL_W-1:0] res_x;
  logic signed [kli_pkg::VAL_W-1:0] res_y;
  logic signed [kli_pkg::VAL_W-1:0] res_z;
  logic [1:0]               res_status;

  kli_pkg::key_t            s_key;
  kli_pkg::key_t            rdata;
  logic                     s_acc;
  logic                     mem_we;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            last;
  logic                     in_seg;
  logic                     zero_span;
  logic                     at_end;
  logic                     out_free;

  kli_pkg::div_req_t        div_req;
  logic                     div_busy;
  logic                     div_done;
  logic [kli_pkg::FRAC_W-1:0] frac;

  logic                     lerp_vin;
  logic signed [kli_pkg::VAL_W-1:0] lerp_v0;
  logic signed [kli_pkg::VAL_W-1:0] lerp_v1;
  logic                     lerp_vout;
  logic signed [kli_pkg::VAL_W-1:0] lerp_res;

  assign s_key    = s_tdata;
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign mem_we   = s_acc && (s_tuser == kli_pkg::REQ_APPEND) && (count < CW'(KEY_DEPTH));
  assign last     = AW'(count - 1'b1);
  assign out_free = !m_tvalid || m_tready;

  // segment test against the key just read and the one before it
  assign in_seg    = (t_q >= lo.t) && (t_q <= rdata.t);
  assign zero_span = (lo.t == rdata.t);
  assign at_end    = (t_q == rdata.t);

  assign div_req.start = (state == S_SCAN) && in_seg && !zero_span && !at_end;
  assign div_req.num   = t_q - lo.t;
  assign div_req.den   = rdata.t - lo.t;

  always_comb begin
    case (state)
      S_IDLE:  raddr = '0;
      S_RD0:   raddr = last;
      S_RDL:   raddr = AW'(1);
      S_SCAN:  raddr = idx + 1'b1;
      default: raddr = '0;
    endcase
  end

  assign lerp_vin = (state == S_MUL) && (mul_cnt != 2'd3);

  always_comb begin
    case (mul_cnt)
      2'd0: begin
        lerp_v0 = lo.x;
        lerp_v1 = hi.x;
      end
      2'd1: begin
        lerp_v0 = lo.y;
        lerp_v1 = hi.y;
      end
      default: begin
        lerp_v0 = lo.z;
        lerp_v1 = hi.z;
      end
    endcase
  end

  kli_key_store #(
    .DEPTH (KEY_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (s_key),
    .raddr (raddr),
    .rdata (rdata)
  );

  kli_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quot (frac)
  );

  kli_lerp u_lerp (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (lerp_vin),
    .v0        (lerp_v0),
    .v1        (lerp_v1),
    .frac      (frac),
    .valid_out (lerp_vout),
    .res       (lerp_res)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      mul_cnt  <= '0;
      col_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            state <= S_RESP;
            if (s_tuser == kli_pkg::REQ_CLEAR) begin
              count <= '0;
            end else if (mem_we) begin
              count <= count + 1'b1;
            end else if (s_tuser == kli_pkg::REQ_EVAL && count != '0) begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= (t_q <= rdata.t) ? S_RESP : S_RDL;
        end
        S_RDL: begin
          state <= (t_q >= rdata.t) ? S_RESP : S_SCAN;
        end
        S_SCAN: begin
          if (div_req.start) begin
            state <= S_DIV;
          end else if (in_seg || idx == last) begin
            state <= S_RESP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state   <= S_MUL;
            mul_cnt <= '0;
            col_cnt <= '0;
          end
        end
        S_MUL: begin
          if (mul_cnt != 2'd3) begin
            mul_cnt <= mul_cnt + 1'b1;
          end
          if (lerp_vout) begin
            col_cnt <= col_cnt + 1'b1;
            if (col_cnt == 2'd2) begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          t_q   <= s_key.t;
          res_x <= '0;
          res_y <= '0;
          res_z <= '0;
          case (s_tuser)
            kli_pkg::REQ_APPEND: res_status <= mem_we ? kli_pkg::ST_OK : kli_pkg::ST_FULL;
            kli_pkg::REQ_EVAL:   res_status <= (count == '0) ? kli_pkg::ST_EMPTY : kli_pkg::ST_EVAL;
            default:             res_status <= kli_pkg::ST_OK;
          endcase
        end
      end
      S_RD0: begin
        lo <= rdata;
        if (t_q <= rdata.t) begin
          res_x <= rdata.x;
          res_y <= rdata.y;
          res_z <= rdata.z;
        end
      end
      S_RDL: begin
        idx <= AW'(1);
        if (t_q >= rdata.t) begin
          res_x <= rdata.x;
          res_y <= rdata.y;
          res_z <= rdata.z;
        end
      end
      S_SCAN: begin
        if (in_seg) begin
          hi <= rdata;
          // flat segment gives the earlier key, an exact hit on the end gives the later one
          if (zero_span) begin
            res_x <= lo.x;
            res_y <= lo.y;
            res_z <= lo.z;
          end else if (at_end) begin
            res_x <= rdata.x;
            res_y <= rdata.y;
            res_z <= rdata.z;
          end
        end else begin
          lo  <= rdata;
          idx <= idx + 1'b1;
          // no segment holds the time: last key
          res_x <= rdata.x;
          res_y <= rdata.y;
          res_z <= rdata.z;
        end
      end
      S_MUL: begin
        if (lerp_vout) begin
          case (col_cnt)
            2'd0:    res_x <= lerp_res;
            2'd1:    res_y <= lerp_res;
            default: res_z <= lerp_res;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_tdata <= {res_z, res_y, res_x};
          m_tuser <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  `KLI_ASSERT(a_count_bound, clk, rst, count <= CW'(KEY_DEPTH), "key count above depth")
  `KLI_ASSERT(a_lerp_in_mul, clk, rst, !lerp_vout || state == S_MUL, "lerp result outside multiply phase")
  `KLI_ASSERT(a_div_in_div, clk, rst, !div_busy || state == S_DIV, "divider busy outside divide phase")
  `KLI_ASSERT_NEXT(a_empty_eval, clk, rst, s_acc && s_tuser == kli_pkg::REQ_EVAL && count == '0, state == S_RESP && res_status == kli_pkg::ST_EMPTY, "empty curve not flagged")

endmodule

>>> design/kli_key_store.sv
module kli_key_store #(
  parameter int DEPTH = kli_pkg::KEY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  kli_pkg::key_t       wdata,
  input  logic [AW-1:0]       raddr,
  output kli_pkg::key_t       rdata
);

  kli_pkg::key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kli_divider.sv
`include "keyframe_linear_interpolator_defines.svh"

// restoring divider, one quotient bit per cycle; numerator below denominator
module kli_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  kli_pkg::div_req_t            req,
  output logic                         busy,
  output logic                         done,
  output logic [kli_pkg::FRAC_W-1:0]   quot
);

  localparam int CNT_W = $clog2(kli_pkg::FRAC_W + 1);

  logic [kli_pkg::TIME_W:0]   rem;
  logic [kli_pkg::TIME_W-1:0] den;
  logic [CNT_W-1:0]           cnt;
  logic [kli_pkg::TIME_W:0]   shifted;

  assign shifted = {rem[kli_pkg::TIME_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(kli_pkg::FRAC_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.num};
      den <= req.den;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem  <= shifted - {1'b0, den};
        quot <= {quot[kli_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[kli_pkg::FRAC_W-2:0], 1'b0};
      end
    end
  end

  `KLI_ASSERT(a_div_no_restart, clk, rst, !(req.start && busy), "divider restarted while busy")
  `KLI_ASSERT_NEXT(a_div_done, clk, rst, busy && cnt == CNT_W'(1), done && !busy, "divider missed done")
  `KLI_ASSERT(a_div_done_idle, clk, rst, !(done && busy), "divider done while busy")

endmodule

>>> design/kli_lerp.sv
// v0 + floor((v1 - v0) * frac / 2^16), product registered before the add
module kli_lerp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid_in,
  input  logic signed [kli_pkg::VAL_W-1:0]   v0,
  input  logic signed [kli_pkg::VAL_W-1:0]   v1,
  input  logic [kli_pkg::FRAC_W-1:0]         frac,
  output logic                               valid_out,
  output logic signed [kli_pkg::VAL_W-1:0]   res
);

  localparam int DW = kli_pkg::VAL_W + 1;
  localparam int PW = DW + kli_pkg::FRAC_W + 1;

  logic signed [DW-1:0]            diff;
  logic signed [kli_pkg::FRAC_W:0] frac_s;
  logic signed [PW-1:0]            prod;
  logic signed [kli_pkg::VAL_W-1:0] v0_q;
  logic                            valid_q;

  assign diff   = $signed({v1[kli_pkg::VAL_W-1], v1}) - $signed({v0[kli_pkg::VAL_W-1], v0});
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q   <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid_q   <= valid_in;
      valid_out <= valid_q;
    end
  end

  // arithmetic shift of the product floors toward minus infinity
  always_ff @(posedge clk) begin
    prod <= diff * frac_s;
    v0_q <= v0;
    res  <= v0_q + prod[kli_pkg::FRAC_W +: kli_pkg::VAL_W];
  end

endmodule

>>> verif/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;

  localparam int         KEY_DEPTH  = kli_pkg::KEY_DEPTH_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         TOTAL_ITEMS = 940;

  typedef struct packed {
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [1:0]  status;
  } vec_result_t;

  class curve_scoreboard;
    bit [31:0]   key_times_m[KEY_DEPTH];
    bit [31:0]   key_x_m[KEY_DEPTH];
    bit [31:0]   key_y_m[KEY_DEPTH];
    bit [31:0]   key_z_m[KEY_DEPTH];
    int unsigned key_cnt;
    vec_result_t expected_vectors[$];
    int errors, n_eval, n_lerp, n_empty, n_append, n_dropped, n_clear, n_unused;

    function new();
      key_cnt = 0;
    endfunction

    function int pending();
      return expected_vectors.size();
    endfunction

    // v0 + floor((v1 - v0) * frac / 65536)
    function bit [31:0] lerp_axis(bit [31:0] a, bit [31:0] b, int frac);
      longint d, prod, r;
      d    = longint'($signed(a));
      prod = (longint'($signed(b)) - d) * longint'(frac);
      r    = d + (prod >>> 16);
      return r[31:0];
    endfunction

    function vec_result_t key_result(int unsigned idx);
      vec_result_t r;
      r.x      = key_x_m[idx];
      r.y      = key_y_m[idx];
      r.z      = key_z_m[idx];
      r.status = kli_pkg::ST_EVAL;
      return r;
    endfunction

    function vec_result_t eval_at(bit [31:0] t);
      vec_result_t r;
      bit [31:0]   t0, t1, span;
      bit [63:0]   frac;
      r = '0;
      if (key_cnt == 0) begin
        r.status = kli_pkg::ST_EMPTY;
        n_empty++;
        return r;
      end
      if (t <= key_times_m[0]) return key_result(0);
      if (t >= key_times_m[key_cnt-1]) return key_result(key_cnt - 1);
      for (int unsigned i = 0; i + 1 < key_cnt; i++) begin
        t0 = key_times_m[i];
        t1 = key_times_m[i+1];
        if (t >= t0 && t <= t1) begin
          span = t1 - t0;
          if (span == 0) return key_result(i);
          if (t == t1) return key_result(i + 1);
          frac = {16'd0, t - t0, 16'd0} / {32'd0, span};
          if (frac > 64'd65535) frac = 64'd65535;
          r.x      = lerp_axis(key_x_m[i], key_x_m[i+1], int'(frac));
          r.y      = lerp_axis(key_y_m[i], key_y_m[i+1], int'(frac));
          r.z      = lerp_axis(key_z_m[i], key_z_m[i+1], int'(frac));
          r.status = kli_pkg::ST_EVAL;
          n_lerp++;
          return r;
        end
      end
      return key_result(key_cnt - 1);
    endfunction

    function void note_request(bit [1:0] req, bit [31:0] t, bit [31:0] x, bit [31:0] y,
                               bit [31:0] z);
      vec_result_t r;
      r = '0;
      r.status = kli_pkg::ST_OK;
      case (req)
        kli_pkg::REQ_CLEAR: begin
          key_cnt = 0;
          n_clear++;
        end
        kli_pkg::REQ_APPEND: begin
          n_append++;
          if (key_cnt < KEY_DEPTH) begin
            key_times_m[key_cnt] = t;
            key_x_m[key_cnt]     = x;
            key_y_m[key_cnt]     = y;
            key_z_m[key_cnt]     = z;
            key_cnt++;
          end else begin
            r.status = kli_pkg::ST_FULL;
            n_dropped++;
          end
        end
        kli_pkg::REQ_EVAL: begin
          n_eval++;
          r = eval_at(t);
        end
        default: n_unused++;
      endcase
      expected_vectors.insert(expected_vectors.size(), r);
    endfunction

    function void check_output(vec_result_t got);
      vec_result_t want;
      if (expected_vectors.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result item: x=%h y=%h z=%h status=%0d",
                   got.x, got.y, got.z, got.status);
        return;
      end
      want = expected_vectors.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: got x=%h y=%h z=%h status=%0d, want x=%h y=%h z=%h status=%0d",
                   $realtime, got.x, got.y, got.z, got.status,
                   want.x, want.y, want.z, want.status);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // time_req, value_x, value_y, value_z
  logic [1:0]   s_tuser = '0;   // req_type
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;        // out_x, out_y, out_z
  logic [1:0]   m_tuser;        // status

  curve_scoreboard sb = new();
  bit              idle_on = 1'b0;
  logic            sink_hold = 1'b0;
  int              n_accepted = 0;
  bit [31:0]       curve_times[$];

  keyframe_linear_interpolator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_req(input bit [1:0] req, input bit [31:0] t, input bit [31:0] x,
                          input bit [31:0] y, input bit [31:0] z);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {z, y, x, t};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, t, x, y, z);
    n_accepted++;
    // mirror of the stored key times, used to aim evaluate times
    case (req)
      kli_pkg::REQ_CLEAR:  curve_times.delete();
      kli_pkg::REQ_APPEND: if (curve_times.size() < KEY_DEPTH)
                             curve_times.insert(curve_times.size(), t);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 32'h0003_0000)) - 32'h0001_8000;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [31:0] probe_time();
    int n, i, j;
    n = curve_times.size();
    if (n == 0) return $urandom();
    i = $urandom_range(0, n - 1);
    j = (i + 1 < n) ? i + 1 : i;
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return curve_times[i];
      2: return curve_times[i] + $urandom_range(1, 3);
      3: return curve_times[i] - $urandom_range(1, 3);
      4: return $urandom_range(0, curve_times[0]);
      5: return $urandom_range(curve_times[n-1], 32'hFFFF_FFFF);
      default: return $urandom_range(curve_times[i], curve_times[j]);
    endcase
  endfunction

  // clear, then n keys in nondecreasing time order with a random spacing scale
  task automatic build_curve(input int n);
    bit [63:0] step_max, tk;
    case ($urandom_range(0, 3))
      0: step_max = 64'd3;
      1: step_max = 64'd256;
      2: step_max = 64'h0004_0000;
      default: step_max = 64'hFFFF_FFFF / (n + 1);
    endcase
    tk = $urandom_range(0, 32'(64'hFFFF_FFFF - step_max * n));
    send_req(kli_pkg::REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
    for (int i = 0; i < n; i++) begin
      send_req(kli_pkg::REQ_APPEND, tk[31:0], rand_val(), rand_val(), rand_val());
      tk += $urandom_range(0, 32'(step_max));
    end
  endtask

  task automatic probe_curve(input int m);
    for (int i = 0; i < m; i++)
      send_req(kli_pkg::REQ_EVAL, probe_time(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_noise(input int m);
    int        pick;
    bit [1:0]  req;
    for (int i = 0; i < m; i++) begin
      pick = $urandom_range(0, 9);
      req  = (pick == 0) ? kli_pkg::REQ_CLEAR : (pick < 5) ? kli_pkg::REQ_APPEND :
             (pick < 8) ? kli_pkg::REQ_EVAL : REQ_UNUSED;
      send_req(req, (req == kli_pkg::REQ_EVAL) ? probe_time() : $urandom(),
               rand_val(), rand_val(), rand_val());
    end
  endtask

  task automatic run_mixed(input int target);
    int pick, n;
    while (n_accepted < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        pick = $urandom_range(0, 9);
        n = (pick < 7) ? $urandom_range(1, 8) :
            (pick < 9) ? $urandom_range(9, 40) : $urandom_range(KEY_DEPTH - 4, KEY_DEPTH + 4);
        build_curve(n);
        probe_curve($urandom_range(3, 12));
      end else begin
        send_noise($urandom_range(2, 8));
      end
    end
  endtask

  // result side: random stall bursts plus the long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_output({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser});
      if (stall_left > 0)
        stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 5);
      m_tready <= !(sink_hold || stall_left > 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty curve, unused code, single key, then a wide swing with duplicate and
    // out-of-order keys
    send_req(kli_pkg::REQ_EVAL, 32'h0000_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'hFFFF_FFFF, '1, '1, '1);
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, '1, '1, '1);
    send_req(kli_pkg::REQ_CLEAR, '0, '0, '0, '0);
    send_req(kli_pkg::REQ_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_req(kli_pkg::REQ_EVAL, 32'h0000_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'hFFFF_FFFF, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'h0001_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_req(kli_pkg::REQ_EVAL, 32'h0002_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'h0002_FFFF, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'h0001_0001, '0, '0, '0);
    send_req(kli_pkg::REQ_APPEND, 32'h0003_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
    send_req(kli_pkg::REQ_APPEND, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
    send_req(kli_pkg::REQ_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001);
    send_req(kli_pkg::REQ_EVAL, 32'h0003_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'h0002_8000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'h8000_0000, '0, '0, '0);
    send_req(kli_pkg::REQ_EVAL, 32'hFFFF_FFFE, '0, '0, '0);
    send_req(kli_pkg::REQ_CLEAR, 32'hFFFF_FFFF, '1, '1, '1);
    send_req(kli_pkg::REQ_EVAL, 32'h0002_0000, '0, '0, '0);

    idle_on = 1'b1;
    build_curve(KEY_DEPTH + 2);
    probe_curve(8);
    run_mixed(350);

    // sink stalls for a long stretch while requests keep coming
    fork
      begin
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        build_curve(12);
        probe_curve(20);
      end
    join

    s_tvalid <= 1'b0;
    wait_drained();
    run_mixed(800);
    idle_on = 1'b0;
    run_mixed(TOTAL_ITEMS);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);

    $display("%0d items: %0d evaluates (%0d interpolated inside a segment, %0d on an empty curve)",
             n_accepted, sb.n_eval, sb.n_lerp, sb.n_empty);
    $display("%0d appends (%0d dropped on a full store), %0d clears, %0d unused codes, %0d errors",
             sb.n_append, sb.n_dropped, sb.n_clear, sb.n_unused, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> keyframe_linear_interpolator.f
+incdir+design
design/kli_pkg.sv
design/kli_key_store.sv
design/kli_divider.sv
design/kli_lerp.sv
design/keyframe_linear_interpolator.sv
verif/keyframe_linear_interpolator_tb.sv
